[rtl/aenc_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aenc_pkg: shared types and constants of the arithmetic encoder
// Field widths, coder constants, state and command types.
// ---------------------------------------------------------------------------
package aenc_pkg;

   // table and coder limits
   localparam int MAX_SYMBOLS = 256;
   localparam int FOLLOW_MAX  = 1023;
   localparam int MAX_RESULTS = 34;
   localparam int TABLE_DEPTH = MAX_SYMBOLS + 1;
   localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
   localparam int DIV_STEPS   = 32;
   localparam int GUARD_LIMIT = 33;

   // field widths
   localparam int OP_W    = 2;
   localparam int SYM_W   = 8;
   localparam int COUNT_W = 16;
   localparam int WORD_W  = 32;
   localparam int BITS_W  = 26;
   localparam int NSYM_W  = 9;
   localparam int CAP_W   = 21;
   localparam int FOLW_W  = 10;
   localparam int CSR_IW  = 2;

   localparam logic [31:0] TOP  = 32'hFFFF_FFFF;
   localparam logic [31:0] QTR1 = 32'h4000_0000;
   localparam logic [31:0] HALF = 32'h8000_0000;
   localparam logic [31:0] QTR3 = 32'hC000_0000;
   localparam logic [BITS_W-1:0] BITS_SAT = '1;

   // opcodes
   localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
   localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
   localparam logic [OP_W-1:0] OP_FINISH = 2'd2;

   // register indexes
   localparam logic [CSR_IW-1:0] CSR_NUM_SYMBOLS = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_CAPACITY    = 2'd1;

   localparam logic [NSYM_W-1:0] NSYM_RESET = 9'd256;
   localparam logic [CAP_W-1:0]  CAP_RESET  = 21'h10_0000;

   typedef enum logic [4:0] {
      ST_IDLE, ST_LOAD, ST_RD_TOT, ST_RD_LO, ST_RD_HI, ST_CAP_HI,
      ST_MUL_HI, ST_DIV_HI, ST_UPD_HI, ST_MUL_LO, ST_DIV_LO, ST_UPD_LO,
      ST_RN_CHECK, ST_PUSH, ST_FOLLOW, ST_FIN_START, ST_FIN_WORD
   } state_type;

   typedef enum logic [1:0] {RD_TOTAL, RD_SYM, RD_SYM_NEXT} rd_sel_type;

   typedef enum logic [1:0] {RN_LOW, RN_HIGH, RN_MID, RN_DONE} rn_case_type;

   typedef struct packed {
      logic       latch_item;
      logic       load_wr;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       cap_total;
      logic       cap_clo;
      logic       cap_chi;
      logic       mul_start;
      logic       mul_hi;
      logic       div_step;
      logic       upd_high;
      logic       upd_low;
      logic       rn_apply;
      logic       push_first;
      logic       push_follow;
      logic       fin_start;
      logic       fin_word;
   } cmd_type;

   typedef struct packed {
      logic        total_zero;
      rn_case_type rn_case;
      logic        follow_nz;
      logic        follow_one;
      logic        out_busy;
   } status_type;

endpackage

[rtl/aenc_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aenc_if: channel interfaces of the arithmetic encoder
// Request, response and register write channels, valid/ready handshake.
// ---------------------------------------------------------------------------
interface aenc_req_if import aenc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    opcode;
   logic [SYM_W-1:0]   symbol_or_index;
   logic [COUNT_W-1:0] count_value;
   modport source (output valid, opcode, symbol_or_index, count_value, input ready);
   modport sink   (input valid, opcode, symbol_or_index, count_value, output ready);
endinterface

interface aenc_rsp_if import aenc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] out_word;
   logic [BITS_W-1:0] total_bits;
   logic              last;
   logic              overflow;
   modport source (output valid, out_word, total_bits, last, overflow, input ready);
   modport sink   (input valid, out_word, total_bits, last, overflow, output ready);
endinterface

interface aenc_csr_if import aenc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CSR_IW-1:0] index;
   logic [CAP_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[rtl/aenc_ram.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aenc_ram: generic single-port-write RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
module aenc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 257
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/aenc_datapath.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aenc_datapath: coder registers, table, multiplier, divider, bit packer
// Acts on commands from the controller and reports status back.
// ---------------------------------------------------------------------------
module aenc_datapath import aenc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic               csr_valid,
   input  logic [CSR_IW-1:0]  csr_index,
   input  logic [CAP_W-1:0]   csr_data,
   input  logic [SYM_W-1:0]   req_symbol,
   input  logic [COUNT_W-1:0] req_count,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic [WORD_W-1:0]  rsp_out_word,
   output logic [BITS_W-1:0]  rsp_total_bits,
   output logic               rsp_last,
   output logic               rsp_overflow
);

   logic [NSYM_W-1:0]  num_sym_ff, num_sym_in;
   logic [CAP_W-1:0]   cap_ff, cap_in;
   logic [SYM_W-1:0]   sym_ff, sym_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [31:0]        load_sum_ff, load_sum_in;
   logic [31:0]        total_ff, total_in;
   logic [31:0]        clo_ff, clo_in;
   logic [31:0]        chi_ff, chi_in;
   logic [31:0]        range_ff, range_in;
   logic [31:0]        rem_ff, rem_in;
   logic [31:0]        quo_ff, quo_in;
   logic [31:0]        low_ff, low_in;
   logic [31:0]        high_ff, high_in;
   logic [FOLW_W-1:0]  follow_ff, follow_in;
   logic [31:0]        acc_ff, acc_in;
   logic [5:0]         bits_left_ff, bits_left_in;
   logic [CAP_W-1:0]   words_ff, words_in;
   logic [BITS_W-1:0]  bit_total_ff, bit_total_in;
   logic               ovf_ff, ovf_in;
   logic [5:0]         res_cnt_ff, res_cnt_in;
   logic               emit_bit_ff, emit_bit_in;
   logic               rd_zero_ff, rd_zero_in;
   logic               valid_ff, valid_in;
   logic [WORD_W-1:0]  word_ff, word_in;
   logic [BITS_W-1:0]  tbits_ff, tbits_in;
   logic               last_ff, last_in;
   logic               oflag_ff, oflag_in;

   logic [TABLE_AW-1:0] rd_addr, wr_addr;
   logic [31:0]         ram_rd, tbl_rd, bound_sat, wr_sum;
   logic [NSYM_W-1:0]   ns_clamp;
   logic [63:0]         prod;
   logic [32:0]         div_t, div_diff;
   logic                div_ge;
   logic                push_en, push_bit;
   logic [31:0]         acc_shift;
   logic                res_room, cap_room;
   rn_case_type         rn_case;

   // cumulative bound table
   aenc_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_table (
      .clock   (clock),
      .wr_en   (cmd.load_wr),
      .wr_addr (wr_addr),
      .wr_data (wr_sum),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_rd)
   );

   // table addressing; entry zero always reads as zero
   assign ns_clamp = (num_sym_ff > NSYM_W'(MAX_SYMBOLS)) ? NSYM_W'(MAX_SYMBOLS) : num_sym_ff;
   assign wr_sum   = (sym_ff == '0) ? 32'(count_ff) : load_sum_ff + 32'(count_ff);
   assign wr_addr  = TABLE_AW'(sym_ff) + TABLE_AW'(1);

   always_comb begin
      case (cmd.rd_sel)
         RD_TOTAL:    rd_addr = TABLE_AW'(ns_clamp);
         RD_SYM:      rd_addr = TABLE_AW'(sym_ff);
         RD_SYM_NEXT: rd_addr = TABLE_AW'(sym_ff) + TABLE_AW'(1);
         default:     rd_addr = '0;
      endcase
   end

   assign tbl_rd    = rd_zero_ff ? 32'd0 : ram_rd;
   assign bound_sat = (tbl_rd > total_ff) ? total_ff : tbl_rd;

   // multiplier and restoring divide step
   assign prod     = 64'(range_ff) * 64'(cmd.mul_hi ? chi_ff : clo_ff);
   assign div_t    = {rem_ff, quo_ff[31]};
   assign div_ge   = div_t >= {1'b0, total_ff};
   assign div_diff = div_t - {1'b0, total_ff};

   // renormalization decision
   always_comb begin
      if (high_ff < HALF) begin
         rn_case = RN_LOW;
      end else if (low_ff >= HALF) begin
         rn_case = RN_HIGH;
      end else if (low_ff >= QTR1 && high_ff < QTR3) begin
         rn_case = RN_MID;
      end else begin
         rn_case = RN_DONE;
      end
   end

   assign push_en   = cmd.push_first | cmd.push_follow;
   assign push_bit  = cmd.push_first ? emit_bit_ff : ~emit_bit_ff;
   assign acc_shift = {acc_ff[30:0], push_bit};
   assign res_room  = res_cnt_ff < 6'(MAX_RESULTS);
   assign cap_room  = words_ff < cap_ff;

   always_comb begin
      num_sym_in   = num_sym_ff;
      cap_in       = cap_ff;
      sym_in       = sym_ff;
      count_in     = count_ff;
      load_sum_in  = load_sum_ff;
      total_in     = total_ff;
      clo_in       = clo_ff;
      chi_in       = chi_ff;
      range_in     = range_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      follow_in    = follow_ff;
      acc_in       = acc_ff;
      bits_left_in = bits_left_ff;
      words_in     = words_ff;
      bit_total_in = bit_total_ff;
      ovf_in       = ovf_ff;
      res_cnt_in   = res_cnt_ff;
      emit_bit_in  = emit_bit_ff;
      rd_zero_in   = rd_zero_ff;
      valid_in     = valid_ff & ~rsp_ready;
      word_in      = word_ff;
      tbits_in     = tbits_ff;
      last_in      = last_ff;
      oflag_in     = oflag_ff;

      // register writes
      if (csr_valid) begin
         case (csr_index)
            CSR_NUM_SYMBOLS: num_sym_in = csr_data[NSYM_W-1:0];
            CSR_CAPACITY:    cap_in     = csr_data;
            default:         ;
         endcase
      end

      if (cmd.latch_item) begin
         sym_in     = req_symbol;
         count_in   = req_count;
         res_cnt_in = '0;
      end
      if (cmd.load_wr) begin
         load_sum_in = wr_sum;
      end
      if (cmd.rd_en) begin
         rd_zero_in = (rd_addr == '0);
      end
      if (cmd.cap_total) begin
         total_in = tbl_rd;
      end
      if (cmd.cap_clo) begin
         clo_in = bound_sat;
      end
      if (cmd.cap_chi) begin
         chi_in   = bound_sat;
         range_in = high_ff - low_ff;
      end
      if (cmd.mul_start) begin
         rem_in = prod[63:32];
         quo_in = prod[31:0];
      end
      if (cmd.div_step) begin
         rem_in = div_ge ? div_diff[31:0] : div_t[31:0];
         quo_in = {quo_ff[30:0], div_ge};
      end
      if (cmd.upd_high) begin
         high_in = low_ff + quo_ff + 32'(rem_ff != '0);
      end
      if (cmd.upd_low) begin
         low_in = low_ff + quo_ff;
      end

      // one renormalization step
      if (cmd.rn_apply) begin
         case (rn_case)
            RN_LOW, RN_HIGH: begin
               emit_bit_in = (rn_case == RN_HIGH);
               low_in      = {low_ff[30:0], 1'b0};
               high_in     = {high_ff[30:0], 1'b1};
            end
            RN_MID: begin
               low_in  = {low_ff[30:0] - QTR1[30:0], 1'b0};
               high_in = {high_ff[30:0] - QTR1[30:0], 1'b1};
               if (follow_ff < FOLW_W'(FOLLOW_MAX)) begin
                  follow_in = follow_ff + FOLW_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
            default: ;
         endcase
      end

      // closing bit: one more follow bit, pushed after the bit itself
      if (cmd.fin_start) begin
         emit_bit_in = (low_ff >= QTR1);
         if (follow_ff < FOLW_W'(FOLLOW_MAX)) begin
            follow_in = follow_ff + FOLW_W'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end

      if (cmd.push_follow) begin
         follow_in = follow_ff - FOLW_W'(1);
      end

      // bit packer
      if (push_en) begin
         if (bit_total_ff != BITS_SAT) begin
            bit_total_in = bit_total_ff + BITS_W'(1);
         end
         if (bits_left_ff == 6'd1) begin
            bits_left_in = 6'd32;
            acc_in       = '0;
            if (cap_room) begin
               words_in = words_ff + CAP_W'(1);
               if (res_room) begin
                  valid_in   = 1'b1;
                  word_in    = acc_shift;
                  tbits_in   = bit_total_in;
                  last_in    = 1'b0;
                  oflag_in   = ovf_ff;
                  res_cnt_in = res_cnt_ff + 6'd1;
               end else begin
                  ovf_in = 1'b1;
               end
            end else begin
               ovf_in = 1'b1;
            end
         end else begin
            acc_in       = acc_shift;
            bits_left_in = bits_left_ff - 6'd1;
         end
      end

      // final left-aligned word, then coder clear
      if (cmd.fin_word) begin
         word_in  = '0;
         oflag_in = ovf_ff;
         if (bits_left_ff != 6'd32) begin
            if (cap_room) begin
               word_in = acc_ff << bits_left_ff;
            end else begin
               oflag_in = 1'b1;
            end
         end
         if (res_room) begin
            valid_in   = 1'b1;
            tbits_in   = bit_total_ff;
            last_in    = 1'b1;
            res_cnt_in = res_cnt_ff + 6'd1;
         end else begin
            word_in  = word_ff;
            oflag_in = oflag_ff;
         end
         low_in       = '0;
         high_in      = TOP;
         follow_in    = '0;
         acc_in       = '0;
         bits_left_in = 6'd32;
         words_in     = '0;
         bit_total_in = '0;
         ovf_in       = 1'b0;
      end
   end

   // control and coder state
   always_ff @(posedge clock) begin
      if (reset) begin
         num_sym_ff   <= NSYM_RESET;
         cap_ff       <= CAP_RESET;
         load_sum_ff  <= '0;
         low_ff       <= '0;
         high_ff      <= TOP;
         follow_ff    <= '0;
         acc_ff       <= '0;
         bits_left_ff <= 6'd32;
         words_ff     <= '0;
         bit_total_ff <= '0;
         ovf_ff       <= 1'b0;
         res_cnt_ff   <= '0;
         valid_ff     <= 1'b0;
      end else begin
         num_sym_ff   <= num_sym_in;
         cap_ff       <= cap_in;
         load_sum_ff  <= load_sum_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         follow_ff    <= follow_in;
         acc_ff       <= acc_in;
         bits_left_ff <= bits_left_in;
         words_ff     <= words_in;
         bit_total_ff <= bit_total_in;
         ovf_ff       <= ovf_in;
         res_cnt_ff   <= res_cnt_in;
         valid_ff     <= valid_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      sym_ff      <= sym_in;
      count_ff    <= count_in;
      total_ff    <= total_in;
      clo_ff      <= clo_in;
      chi_ff      <= chi_in;
      range_ff    <= range_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      emit_bit_ff <= emit_bit_in;
      rd_zero_ff  <= rd_zero_in;
      word_ff     <= word_in;
      tbits_ff    <= tbits_in;
      last_ff     <= last_in;
      oflag_ff    <= oflag_in;
   end

   assign status.total_zero = (total_ff == '0);
   assign status.rn_case    = rn_case;
   assign status.follow_nz  = (follow_ff != '0);
   assign status.follow_one = (follow_ff == FOLW_W'(1));
   assign status.out_busy   = valid_ff;

   assign rsp_valid      = valid_ff;
   assign rsp_out_word   = word_ff;
   assign rsp_total_bits = tbits_ff;
   assign rsp_last       = last_ff;
   assign rsp_overflow   = oflag_ff;

endmodule

[rtl/aenc_control.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aenc_control: sequencer of the arithmetic encoder
// Steps table reads, the two divisions, renormalization and bit output.
// ---------------------------------------------------------------------------
module aenc_control import aenc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic [OP_W-1:0] req_opcode,
   output logic            req_ready,
   input  status_type      status,
   output cmd_type         cmd
);

   state_type  state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;
   logic       fin_ff, fin_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         fin_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         fin_ff   <= fin_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      fin_in    = fin_ff;
      cmd       = '0;
      cmd.rd_sel = RD_TOTAL;
      req_ready = (state_ff == ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch_item = 1'b1;
               case (req_opcode)
                  OP_LOAD:   state_in = ST_LOAD;
                  OP_ENCODE: state_in = ST_RD_TOT;
                  OP_FINISH: state_in = ST_FIN_START;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_LOAD: begin
            cmd.load_wr = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_RD_TOT: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_TOTAL;
            state_in   = ST_RD_LO;
         end
         ST_RD_LO: begin
            cmd.rd_en     = 1'b1;
            cmd.rd_sel    = RD_SYM;
            cmd.cap_total = 1'b1;
            state_in      = ST_RD_HI;
         end
         ST_RD_HI: begin
            if (status.total_zero) begin
               state_in = ST_IDLE;
            end else begin
               cmd.rd_en   = 1'b1;
               cmd.rd_sel  = RD_SYM_NEXT;
               cmd.cap_clo = 1'b1;
               state_in    = ST_CAP_HI;
            end
         end
         ST_CAP_HI: begin
            cmd.cap_chi = 1'b1;
            state_in    = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            cmd.mul_start = 1'b1;
            cmd.mul_hi    = 1'b1;
            cnt_in        = '0;
            state_in      = ST_DIV_HI;
         end
         ST_DIV_HI: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 6'd1;
            if (cnt_ff == 6'(DIV_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = ST_UPD_HI;
            end
         end
         ST_UPD_HI: begin
            cmd.upd_high = 1'b1;
            state_in     = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            cmd.mul_start = 1'b1;
            cnt_in        = '0;
            state_in      = ST_DIV_LO;
         end
         ST_DIV_LO: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 6'd1;
            if (cnt_ff == 6'(DIV_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = ST_UPD_LO;
            end
         end
         ST_UPD_LO: begin
            cmd.upd_low = 1'b1;
            cnt_in      = '0;
            state_in    = ST_RN_CHECK;
         end
         // cnt counts renormalization steps here
         ST_RN_CHECK: begin
            if (cnt_ff == 6'(GUARD_LIMIT) || status.rn_case == RN_DONE) begin
               state_in = ST_IDLE;
            end else begin
               cmd.rn_apply = 1'b1;
               cnt_in       = cnt_ff + 6'd1;
               state_in     = (status.rn_case == RN_MID) ? ST_RN_CHECK : ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (!status.out_busy) begin
               cmd.push_first = 1'b1;
               if (status.follow_nz) begin
                  state_in = ST_FOLLOW;
               end else begin
                  state_in = fin_ff ? ST_FIN_WORD : ST_RN_CHECK;
               end
            end
         end
         ST_FOLLOW: begin
            if (!status.out_busy) begin
               cmd.push_follow = 1'b1;
               if (status.follow_one) begin
                  state_in = fin_ff ? ST_FIN_WORD : ST_RN_CHECK;
               end
            end
         end
         ST_FIN_START: begin
            cmd.fin_start = 1'b1;
            fin_in        = 1'b1;
            state_in      = ST_PUSH;
         end
         ST_FIN_WORD: begin
            if (!status.out_busy) begin
               cmd.fin_word = 1'b1;
               fin_in       = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[rtl/arithmetic_encoder_32bit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// arithmetic_encoder_32bit: 32-bit arithmetic encoder, loadable table
// Top level: controller plus datapath, channel wiring.
// ---------------------------------------------------------------------------
// Usage:
//   req_chan carries one command word: load a count (opcode 0), encode a
//   symbol (opcode 1) or finish the stream (opcode 2). rsp_chan returns one
//   word per 32 completed code bits, MSB first; a finish returns a final
//   left-aligned word with last set. csr_chan writes num_symbols (index 0)
//   and capacity_words (index 1) and is always ready; write only while idle.
//   An encode runs two 32-step restoring divisions, then renormalizes one
//   step at a time and pushes each emitted bit; a zero-total encode ends
//   after the table reads. A finish adds one follow bit, then pushes the
//   closing bit, its follow bits and the final word.
//   Reset clears the coder and sets the registers to their defaults; the
//   count table is not cleared and must be loaded from index 0 before use.
//   A result word sits in an output register; while the receiver stalls,
//   bit packing halts at the next bit until that register is free. New
//   commands are taken as soon as the sequencer is back in idle.
// ---------------------------------------------------------------------------
module arithmetic_encoder_32bit import aenc_pkg::*; (
   input  logic clock,
   input  logic reset,
   aenc_req_if.sink   req_chan,
   aenc_rsp_if.source rsp_chan,
   aenc_csr_if.sink   csr_chan
);

   cmd_type    cmd;
   status_type status;
   logic       ctl_ready;

   aenc_control u_control (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_opcode (req_chan.opcode),
      .req_ready  (ctl_ready),
      .status     (status),
      .cmd        (cmd)
   );

   aenc_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .csr_valid      (csr_chan.valid),
      .csr_index      (csr_chan.index),
      .csr_data       (csr_chan.data),
      .req_symbol     (req_chan.symbol_or_index),
      .req_count      (req_chan.count_value),
      .rsp_ready      (rsp_chan.ready),
      .rsp_valid      (rsp_chan.valid),
      .rsp_out_word   (rsp_chan.out_word),
      .rsp_total_bits (rsp_chan.total_bits),
      .rsp_last       (rsp_chan.last),
      .rsp_overflow   (rsp_chan.overflow)
   );

   assign req_chan.ready = ctl_ready;
   assign csr_chan.ready = 1'b1;

endmodule

[tb/aenc_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aenc_checker: predictor and scoreboard of the arithmetic encoder
// Watches the command, result and register channels. Each accepted command
// word runs through a bit-exact model of the coder; the result words it
// yields wait in order and are compared field by field with the block's.
// ---------------------------------------------------------------------------
module aenc_checker import aenc_pkg::*; (
   input  logic clock,
   input  logic reset,
   aenc_req_if  req_mon,
   aenc_rsp_if  rsp_mon,
   aenc_csr_if  csr_mon,
   output int   fail_count,
   output int   words_due
);

   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic [BITS_W-1:0] bits;
      logic              last;
      logic              ovf;
   } code_word_type;

   code_word_type due_words[$];

   // model state
   logic [31:0]       cum_tbl [0:TABLE_DEPTH-1];
   logic [31:0]       run_sum;
   logic [31:0]       lo_q, hi_q;
   int unsigned       pend_cnt;
   logic [31:0]       acc_q;
   int                free_bits;
   logic [CAP_W-1:0]  emitted;
   logic [BITS_W-1:0] bit_cnt;
   logic              ovf_q;
   logic [NSYM_W-1:0] nsym_q;
   logic [CAP_W-1:0]  cap_q;
   int                step_words;
   int                mism;

   assign words_due = due_words.size();

   task clear_coder();
      lo_q = '0; hi_q = TOP; pend_cnt = 0; acc_q = '0; free_bits = 32;
      emitted = '0; bit_cnt = '0; ovf_q = 1'b0;
   endtask

   task queue_word(input logic [31:0] w, input logic lst);
      code_word_type cw;
      if (step_words < MAX_RESULTS) begin
         cw.word = w; cw.bits = bit_cnt; cw.last = lst; cw.ovf = ovf_q;
         due_words.push_back(cw);
         step_words++;
      end else begin
         ovf_q = 1'b1;
      end
   endtask

   task shift_bit(input logic b);
      acc_q = {acc_q[30:0], b};
      free_bits--;
      if (bit_cnt != BITS_SAT) bit_cnt++;
      if (free_bits == 0) begin
         free_bits = 32;
         if (emitted < cap_q) begin
            emitted++;
            queue_word(acc_q, 1'b0);
         end else begin
            ovf_q = 1'b1;
         end
         acc_q = '0;
      end
   endtask

   task emit_bit(input logic b);
      shift_bit(b);
      while (pend_cnt > 0) begin
         pend_cnt--;
         shift_bit(~b);
      end
   endtask

   task bump_pending();
      if (pend_cnt < FOLLOW_MAX) pend_cnt++;
      else ovf_q = 1'b1;
   endtask

   function automatic logic [31:0] bound_at(input int i);
      if (i > MAX_SYMBOLS) i = MAX_SYMBOLS;
      return cum_tbl[i];
   endfunction

   task encode_sym(input int sym);
      int          ns;
      logic [31:0] total, clo, chi, span;
      logic [63:0] p, q;
      ns = (nsym_q > MAX_SYMBOLS) ? MAX_SYMBOLS : nsym_q;
      total = bound_at(ns);
      if (total != 0) begin
         clo = bound_at(sym);
         chi = bound_at(sym + 1);
         if (clo > total) clo = total;
         if (chi > total) chi = total;
         span = hi_q - lo_q;
         p = 64'(span) * 64'(chi);
         q = p / 64'(total);
         if (p % 64'(total) != 0) q++;
         hi_q = lo_q + q[31:0];
         p = 64'(span) * 64'(clo);
         q = p / 64'(total);
         lo_q = lo_q + q[31:0];
         // renormalize, at most GUARD_LIMIT shifts
         for (int g = 0; g < GUARD_LIMIT; g++) begin
            if (hi_q < HALF) begin
               emit_bit(1'b0);
            end else if (lo_q >= HALF) begin
               emit_bit(1'b1);
               lo_q -= HALF; hi_q -= HALF;
            end else if (lo_q >= QTR1 && hi_q < QTR3) begin
               bump_pending();
               lo_q -= QTR1; hi_q -= QTR1;
            end else begin
               break;
            end
            lo_q = {lo_q[30:0], 1'b0};
            hi_q = {hi_q[30:0], 1'b1};
         end
      end
   endtask

   task finish_sym();
      logic [31:0] w;
      w = '0;
      bump_pending();
      emit_bit((lo_q < QTR1) ? 1'b0 : 1'b1);
      if (free_bits < 32) begin
         if (emitted < cap_q) begin
            emitted++;
            w = acc_q << free_bits;
         end else begin
            ovf_q = 1'b1;
         end
      end
      queue_word(w, 1'b1);
      clear_coder();
   endtask

   task code_command(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] idx,
                     input logic [COUNT_W-1:0] cnt);
      step_words = 0;
      case (op)
         OP_LOAD: begin
            if (idx == 0) begin
               cum_tbl[0] = '0;
               run_sum = 32'(cnt);
            end else begin
               run_sum = run_sum + 32'(cnt);
            end
            cum_tbl[int'(idx) + 1] = run_sum;
         end
         OP_ENCODE: encode_sym(int'(idx));
         OP_FINISH: finish_sym();
         default: ;
      endcase
   endtask

   // monitor all three channels
   always @(posedge clock) begin
      code_word_type exp_w;
      if (reset) begin
         due_words.delete();
         run_sum = '0;
         clear_coder();
         nsym_q = NSYM_RESET;
         cap_q  = CAP_RESET;
         fail_count = 0;
         mism = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (due_words.size() == 0) begin
               fail_count++;
               if (mism < 10)
                  $display("unexpected result word %h bits %0d last %b ovf %b",
                           rsp_mon.out_word, rsp_mon.total_bits, rsp_mon.last,
                           rsp_mon.overflow);
               mism++;
            end else begin
               exp_w = due_words.pop_front();
               if (exp_w.word !== rsp_mon.out_word || exp_w.bits !== rsp_mon.total_bits ||
                   exp_w.last !== rsp_mon.last || exp_w.ovf !== rsp_mon.overflow) begin
                  fail_count++;
                  if (mism < 10)
                     $display("word mismatch: exp %h/%0d/%b/%b got %h/%0d/%b/%b",
                              exp_w.word, exp_w.bits, exp_w.last, exp_w.ovf,
                              rsp_mon.out_word, rsp_mon.total_bits, rsp_mon.last,
                              rsp_mon.overflow);
                  mism++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            code_command(req_mon.opcode, req_mon.symbol_or_index, req_mon.count_value);
         if (csr_mon.valid && csr_mon.ready) begin
            if (csr_mon.index == CSR_NUM_SYMBOLS) nsym_q = csr_mon.data[NSYM_W-1:0];
            else if (csr_mon.index == CSR_CAPACITY) cap_q = csr_mon.data;
         end
      end
   end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: stimulus and verdict for the arithmetic encoder
// Loads count tables, encodes symbol streams and finishes them under
// several register settings, with random idle bursts on both channels.
// ---------------------------------------------------------------------------
module tb_top;
   import aenc_pkg::*;

   logic clock;
   logic reset;
   int   fail_count;
   int   words_due;
   bit   idle_on;

   aenc_req_if req_chan ();
   aenc_rsp_if rsp_chan ();
   aenc_csr_if csr_chan ();

   arithmetic_encoder_32bit DUT (
      .clock(clock), .reset(reset),
      .req_chan(req_chan), .rsp_chan(rsp_chan), .csr_chan(csr_chan)
   );

   aenc_checker u_checker (
      .clock(clock), .reset(reset),
      .req_mon(req_chan), .rsp_mon(rsp_chan), .csr_mon(csr_chan),
      .fail_count(fail_count), .words_due(words_due)
   );

   // clock, 20 ns period
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // overall limit
   initial begin
      #40_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // send one command word, with an optional idle burst first
   task send_cmd(input logic [OP_W-1:0] op, input int idx, input int cnt);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_chan.valid           <= 1'b1;
      req_chan.opcode          <= op;
      req_chan.symbol_or_index <= idx[SYM_W-1:0];
      req_chan.count_value     <= cnt[COUNT_W-1:0];
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task csr_write(input logic [CSR_IW-1:0] idx, input int val);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= val[CAP_W-1:0];
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
   endtask

   // drain, then let any silent encode finish before a register write
   task set_regs(input int nsym, input int cap);
      req_chan.valid <= 1'b0;
      wait (words_due == 0);
      repeat (1500) @(posedge clock);
      csr_write(CSR_NUM_SYMBOLS, nsym);
      csr_write(CSR_CAPACITY, cap);
   endtask

   function automatic int rand_count();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return 1;
         2: return 65535;
         default: return $urandom_range(0, 65535);
      endcase
   endfunction

   // a symbol whose two bounds have been loaded: the low block or the top one
   function automatic int rand_sym();
      return ($urandom_range(0, 1) != 0) ? 255 : $urandom_range(0, 63);
   endfunction

   // random commands under the current setting
   task random_phase(input int nsym, input int n);
      int lim, sl, k, r;
      lim = (nsym > MAX_SYMBOLS) ? MAX_SYMBOLS : nsym;
      sl  = (lim < 64) ? lim : 64;
      // reload a table prefix from index zero
      k = $urandom_range(1, (lim < 24) ? lim : 24);
      for (int i = 0; i < k; i++) send_cmd(OP_LOAD, i, rand_count());
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 84)
            send_cmd(OP_ENCODE, ($urandom_range(0, 7) != 0) ?
                     $urandom_range(0, sl - 1) : rand_sym(), 0);
         else if (r < 91) send_cmd(OP_FINISH, $urandom_range(0, 255), $urandom_range(0, 65535));
         else if (r < 95) send_cmd(OP_LOAD, $urandom_range(0, 255), rand_count());
         else send_cmd(2'd3, $urandom_range(0, 255), $urandom_range(0, 65535));
      end
      send_cmd(OP_FINISH, 0, 0);
   endtask

   // result-side stalls
   initial begin
      rsp_chan.ready = 1'b1;
      @(negedge reset);
      forever begin
         if (idle_on && $urandom_range(0, 2) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   end

   initial begin
      int nsyms [7] = '{256, 3, 1, 511, 17, 64, 256};
      int caps  [7] = '{1048576, 2, 1, 0, 2097151, 5, 1048576};
      reset = 1'b1;
      idle_on = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.opcode = OP_LOAD;
      req_chan.symbol_or_index = '0;
      req_chan.count_value = '0;
      csr_chan.valid = 1'b0;
      csr_chan.index = CSR_NUM_SYMBOLS;
      csr_chan.data = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // write the low block of the table and its top two entries
      for (int i = 0; i < 64; i++) send_cmd(OP_LOAD, i, rand_count());
      send_cmd(OP_LOAD, 254, rand_count());
      send_cmd(OP_LOAD, 255, rand_count());
      send_cmd(OP_ENCODE, 0, 0);
      send_cmd(OP_ENCODE, 255, 65535);
      send_cmd(OP_ENCODE, 32, 0);
      send_cmd(2'd3, 255, 65535);
      send_cmd(OP_FINISH, 0, 0);
      send_cmd(OP_FINISH, 0, 0);

      // narrow centered symbol: piles up follow bits until they saturate
      set_regs(3, 1048576);
      send_cmd(OP_LOAD, 0, 65535);
      send_cmd(OP_LOAD, 1, 1);
      send_cmd(OP_LOAD, 2, 65535);
      repeat (64) send_cmd(OP_ENCODE, 1, 0);
      send_cmd(OP_FINISH, 0, 0);

      // zero total: encodes leave the interval alone
      set_regs(2, 1048576);
      send_cmd(OP_LOAD, 0, 0);
      send_cmd(OP_LOAD, 1, 0);
      send_cmd(OP_ENCODE, 0, 0);
      send_cmd(OP_ENCODE, 1, 0);
      send_cmd(OP_FINISH, 0, 0);

      // table with stale bounds above the total, and symbols past the table
      set_regs(4, 1048576);
      send_cmd(OP_LOAD, 0, 65535);
      send_cmd(OP_LOAD, 1, 3);
      send_cmd(OP_ENCODE, 3, 0);
      send_cmd(OP_ENCODE, 255, 0);
      send_cmd(OP_ENCODE, 0, 0);
      send_cmd(OP_FINISH, 0, 0);

      for (int ph = 0; ph < 7; ph++) begin
         set_regs(nsyms[ph], caps[ph]);
         if (ph == 6) idle_on = 1'b0;
         random_phase(nsyms[ph], 20);
      end
      req_chan.valid <= 1'b0;

      wait (words_due == 0);
      repeat (2000) @(posedge clock);
      if (fail_count == 0 && words_due == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
